>>> sv/skf_pkg.sv
// shared types, constants and control store for the scalar kalman filter
// no dependencies; used by scalar_kalman_filter and its checker
package skf_pkg;

  localparam int DATA_W        = 32;
  localparam int HALF_W        = 16;
  localparam int FRAC_BITS_DEF = 16;
  localparam int PC_W          = 4;
  localparam int CFG_IDX_W     = 2;

  localparam logic [DATA_W-1:0] Q_RESET = 32'd1310720;
  localparam logic [DATA_W-1:0] R_RESET = 32'd13107200;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROCESS_NOISE     = 2'd0,
    REG_MEASUREMENT_NOISE = 2'd1
  } cfg_reg_t;

  // datapath operation of one step
  typedef enum logic [3:0] {
    OP_NOP,
    OP_LOAD,
    OP_PRIOR,
    OP_DENOM,
    OP_DIV,
    OP_GAIN,
    OP_MUL_DH,
    OP_MUL_DL,
    OP_MUL_PH,
    OP_EST,
    OP_ACC,
    OP_EMIT
  } op_t;

  // jump condition: jump to target when true, else fall through
  typedef enum logic [2:0] {
    JC_NONE,
    JC_ALWAYS,
    JC_NO_IN,
    JC_CNT,
    JC_OUT_BUSY
  } jc_t;

  typedef logic [PC_W-1:0] pc_t;

  typedef struct packed {
    op_t op;
    jc_t jc;
    pc_t target;
  } ucode_t;

  localparam pc_t PC_IDLE = 4'd0;
  localparam pc_t PC_DIV  = 4'd3;
  localparam pc_t PC_EMIT = 4'd10;

  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t w;
    case (pc)
      4'd0:    w = '{OP_LOAD,   JC_NO_IN,    PC_IDLE};
      4'd1:    w = '{OP_PRIOR,  JC_NONE,     PC_IDLE};
      4'd2:    w = '{OP_DENOM,  JC_NONE,     PC_IDLE};
      4'd3:    w = '{OP_DIV,    JC_CNT,      PC_DIV};
      4'd4:    w = '{OP_GAIN,   JC_NONE,     PC_IDLE};
      4'd5:    w = '{OP_MUL_DH, JC_NONE,     PC_IDLE};
      4'd6:    w = '{OP_MUL_DL, JC_NONE,     PC_IDLE};
      4'd7:    w = '{OP_MUL_PH, JC_NONE,     PC_IDLE};
      4'd8:    w = '{OP_EST,    JC_NONE,     PC_IDLE};
      4'd9:    w = '{OP_ACC,    JC_NONE,     PC_IDLE};
      4'd10:   w = '{OP_EMIT,   JC_OUT_BUSY, PC_EMIT};
      4'd11:   w = '{OP_NOP,    JC_ALWAYS,   PC_IDLE};
      default: w = '{OP_NOP,    JC_ALWAYS,   PC_IDLE};
    endcase
    return w;
  endfunction

endpackage

>>> sv/scalar_kalman_filter.sv
// scalar kalman filter, unit state and measurement models, fixed point
// microcoded sequencer over a shared divider step, multiplier and accumulator
// depends on skf_pkg
//
// Each accepted sample (signed Q16.16) updates the stored estimate and error
// covariance and yields one estimate beat. The gain is formed by a restoring
// divider, one quotient bit per cycle, and the update uses four 18-bit
// partial products on one multiplier. A new sample is not taken until the
// last one has been emitted. The input is taken only while the sequencer
// sits at its idle step; a finished estimate waits in the output register
// while the next sample is taken. The user must write process and
// measurement noise through the cfg port only while the block is idle; the
// block itself does not enforce this. An index beyond the two is ignored.
module scalar_kalman_filter #(
  parameter int FRAC_BITS = skf_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [skf_pkg::DATA_W-1:0]     in_tdata,   // [31:0] sample
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [skf_pkg::DATA_W-1:0]     out_tdata,  // [31:0] estimate
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [skf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [skf_pkg::DATA_W-1:0]     cfg_data
);

  localparam int DW     = skf_pkg::DATA_W;
  localparam int HW     = skf_pkg::HALF_W;
  localparam int GAIN_W = FRAC_BITS + 1;
  localparam int CNT_W  = $clog2(GAIN_W);
  localparam int MUL_W  = GAIN_W + 1 + HW + 2;
  localparam int ACC_W  = FRAC_BITS + 36;
  localparam logic [GAIN_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

  skf_pkg::pc_t    pc_r, pc_nxt;
  skf_pkg::ucode_t uw;

  logic signed [DW-1:0]    z_r, z_nxt;
  logic signed [DW-1:0]    x_r, x_nxt;
  logic [DW-1:0]           cov_r, cov_nxt;
  logic [DW-1:0]           qn_r, qn_nxt;
  logic [DW-1:0]           rn_r, rn_nxt;
  logic [DW-1:0]           prior_r, prior_nxt;
  logic signed [DW:0]      diff_r, diff_nxt;
  logic [DW:0]             denom_r, denom_nxt;
  logic                    den_zero_r, den_zero_nxt;
  logic [DW+1:0]           rem_r, rem_nxt;
  logic [GAIN_W-1:0]       gain_r, gain_nxt;
  logic [CNT_W-1:0]        cnt_r, cnt_nxt;
  logic signed [MUL_W-1:0] mul_r, mul_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic [DW-1:0]           out_data_r, out_data_nxt;

  logic                    in_acc;
  logic                    out_free;
  logic                    jump;
  logic [DW:0]             prior_sum;
  logic                    div_ge;
  logic [DW+1:0]           div_keep;
  logic [GAIN_W-1:0]       inv_gain;
  logic signed [GAIN_W:0]  mul_a;
  logic signed [HW+1:0]    mul_b;
  logic signed [MUL_W-1:0] mul_p;
  logic signed [ACC_W-1:0] mul_ext;
  logic signed [ACC_W-1:0] acc_sh;
  logic signed [DW+1:0]    est_w;
  logic signed [DW-1:0]    est_sat;

  assign uw        = skf_pkg::ucode_rom(pc_r);
  assign in_tready = (pc_r == skf_pkg::PC_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // sequencer
  always_comb begin
    case (uw.jc)
      skf_pkg::JC_NONE:     jump = 1'b0;
      skf_pkg::JC_ALWAYS:   jump = 1'b1;
      skf_pkg::JC_NO_IN:    jump = !in_acc;
      skf_pkg::JC_CNT:      jump = (cnt_r != '0);
      skf_pkg::JC_OUT_BUSY: jump = !out_free;
      default:              jump = 1'b1;
    endcase
    pc_nxt = jump ? uw.target : skf_pkg::pc_t'(pc_r + 1'b1);
  end

  // shared arithmetic
  always_comb begin
    prior_sum = {1'b0, cov_r} + {1'b0, qn_r};
    div_ge    = (rem_r >= {1'b0, denom_r});
    div_keep  = div_ge ? (rem_r - {1'b0, denom_r}) : rem_r;
    inv_gain  = ONE - gain_r;

    case (uw.op)
      skf_pkg::OP_MUL_PH,
      skf_pkg::OP_EST:   mul_a = $signed({1'b0, inv_gain});
      default:           mul_a = $signed({1'b0, gain_r});
    endcase
    case (uw.op)
      skf_pkg::OP_MUL_DH: mul_b = $signed({diff_r[DW], diff_r[DW:HW]});
      skf_pkg::OP_MUL_DL: mul_b = $signed({2'b00, diff_r[HW-1:0]});
      skf_pkg::OP_MUL_PH: mul_b = $signed({2'b00, prior_r[DW-1:HW]});
      default:            mul_b = $signed({2'b00, prior_r[HW-1:0]});
    endcase
    mul_p   = MUL_W'(mul_a) * MUL_W'(mul_b);
    mul_ext = ACC_W'(mul_r);

    // arithmetic shift is the floor of the product over one
    acc_sh  = acc_r >>> FRAC_BITS;
    est_w   = (DW+2)'(x_r) + (DW+2)'(acc_sh);
    if (est_w[DW+1:DW-1] == 3'b000 || est_w[DW+1:DW-1] == 3'b111) begin
      est_sat = est_w[DW-1:0];
    end else begin
      est_sat = est_w[DW+1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end
  end

  // datapath
  always_comb begin
    z_nxt         = z_r;
    x_nxt         = x_r;
    cov_nxt       = cov_r;
    qn_nxt        = qn_r;
    rn_nxt        = rn_r;
    prior_nxt     = prior_r;
    diff_nxt      = diff_r;
    denom_nxt     = denom_r;
    den_zero_nxt  = den_zero_r;
    rem_nxt       = rem_r;
    gain_nxt      = gain_r;
    cnt_nxt       = cnt_r;
    mul_nxt       = mul_r;
    acc_nxt       = acc_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_data_nxt  = out_data_r;

    if (cfg_valid && cfg_ready) begin
      case (skf_pkg::cfg_reg_t'(cfg_index))
        skf_pkg::REG_PROCESS_NOISE:     qn_nxt = cfg_data;
        skf_pkg::REG_MEASUREMENT_NOISE: rn_nxt = cfg_data;
        default: ;
      endcase
    end

    case (uw.op)
      skf_pkg::OP_LOAD: begin
        if (in_acc) begin
          z_nxt = in_tdata;
        end
      end
      skf_pkg::OP_PRIOR: begin
        prior_nxt = prior_sum[DW] ? '1 : prior_sum[DW-1:0];
        diff_nxt  = (DW+1)'(z_r) - (DW+1)'(x_r);
      end
      skf_pkg::OP_DENOM: begin
        denom_nxt    = {1'b0, prior_r} + {1'b0, rn_r};
        den_zero_nxt = (prior_r == '0) && (rn_r == '0);
        rem_nxt      = {2'b00, prior_r};
        gain_nxt     = '0;
        cnt_nxt      = CNT_W'(FRAC_BITS);
      end
      skf_pkg::OP_DIV: begin
        // remainder stays below twice the divisor, so the shift cannot overflow
        gain_nxt = {gain_r[GAIN_W-2:0], div_ge};
        rem_nxt  = {div_keep[DW:0], 1'b0};
        cnt_nxt  = cnt_r - 1'b1;
      end
      skf_pkg::OP_GAIN: begin
        if (den_zero_r) begin
          gain_nxt = '0;
        end
      end
      skf_pkg::OP_MUL_DH: begin
        mul_nxt = mul_p;
      end
      skf_pkg::OP_MUL_DL: begin
        acc_nxt = mul_ext <<< HW;
        mul_nxt = mul_p;
      end
      skf_pkg::OP_MUL_PH: begin
        acc_nxt = acc_r + mul_ext;
        mul_nxt = mul_p;
      end
      skf_pkg::OP_EST: begin
        x_nxt   = est_sat;
        acc_nxt = mul_ext <<< HW;
        mul_nxt = mul_p;
      end
      skf_pkg::OP_ACC: begin
        acc_nxt = acc_r + mul_ext;
      end
      skf_pkg::OP_EMIT: begin
        if (out_free) begin
          cov_nxt       = acc_r[FRAC_BITS+DW-1:FRAC_BITS];
          out_valid_nxt = 1'b1;
          out_data_nxt  = x_r;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= skf_pkg::PC_IDLE;
      out_valid_r <= 1'b0;
      x_r         <= '0;
      cov_r       <= '0;
      qn_r        <= skf_pkg::Q_RESET;
      rn_r        <= skf_pkg::R_RESET;
      cnt_r       <= '0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      x_r         <= x_nxt;
      cov_r       <= cov_nxt;
      qn_r        <= qn_nxt;
      rn_r        <= rn_nxt;
      cnt_r       <= cnt_nxt;
    end
    z_r        <= z_nxt;
    prior_r    <= prior_nxt;
    diff_r     <= diff_nxt;
    denom_r    <= denom_nxt;
    den_zero_r <= den_zero_nxt;
    rem_r      <= rem_nxt;
    gain_r     <= gain_nxt;
    mul_r      <= mul_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

>>> sv/skf_checker.sv
// port-level checks for scalar_kalman_filter, bound to the top level
// depends on skf_pkg
module skf_checker (
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_tvalid,
  input logic                       in_tready,
  input logic                       out_tvalid,
  input logic                       out_tready,
  input logic [skf_pkg::DATA_W-1:0] out_tdata
);

  // no estimate is pending right after reset
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("out_tvalid high after reset");

  // one sample in flight: the sequencer leaves idle after each input beat
  a_one_inflight: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while a sample is in work");

  // a new estimate is only produced at the end of a sample's program
  a_out_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !in_tready)
    else $error("estimate appeared while idle");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("stalled estimate beat changed");

endmodule

bind scalar_kalman_filter skf_checker u_skf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
